>>> rtl/core/dlha_pkg.sv
`default_nettype none
package dlha_pkg;

  localparam int ADDR_W = 32;
  localparam int CFG_W  = 32;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_RECYCLE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPARE  = 2'd1,
    ST_NO_MEM    = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_t;

  typedef enum logic {
    REG_POOL_BASE  = 1'b0,
    REG_POOL_BYTES = 1'b1
  } reg_idx_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] req_size;
    logic [12:0] alignment;
    logic [31:0] block_address;
  } dlha_in_t;

  typedef struct packed {
    logic [31:0] granted_address;
    status_t     status;
  } dlha_out_t;

endpackage
`default_nettype wire

>>> rtl/core/dlha_ram.sv
`default_nettype none
module dlha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/core/descriptor_list_heap_allocator.sv
`default_nettype none
// First-fit heap allocator over a table of NUM_DESC descriptors (base, length,
// link) held in one single-port-read RAM. One command (allocate, release,
// coalesce-and-sort) is taken when start is high and busy is low; busy stays
// high until its single result is shown on out_data for one cycle with
// out_valid. The receiver cannot stall; a new command may be started in the
// cycle the result is shown. Each visited descriptor is first read from the
// RAM and then evaluated: allocate first rounds the size up to the alignment
// with a bit-serial division and then walks the free list, release walks the
// used list and then the free list, coalesce is quadratic in the free blocks
// and is followed by the sort, also quadratic. After reset and after every
// configuration write, a rebuild pass over all NUM_DESC descriptors runs with busy high.
module descriptor_list_heap_allocator #(
  parameter int NUM_DESC   = 64,
  parameter int DESC_BYTES = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire dlha_pkg::dlha_in_t   in_data,
  output logic                      out_valid,
  output dlha_pkg::dlha_out_t       out_data,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [dlha_pkg::CFG_W-1:0] cfg_wdata
);
  import dlha_pkg::*;

  localparam int AW = $clog2(NUM_DESC);
  localparam int LW = $clog2(NUM_DESC + 1);
  localparam logic [LW-1:0] NIL = LW'(NUM_DESC);
  localparam logic [ADDR_W-1:0] TOTAL = ADDR_W'(NUM_DESC * DESC_BYTES);

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] len;
    logic [LW-1:0]     link;
  } desc_t;

  localparam int DW = $bits(desc_t);

  typedef enum logic [5:0] {
    S_INIT, S_IDLE,
    A_DIV, A_SIZE, A_RD, A_EV, A_UNLINK, A_TAKE, A_SPLIT, A_SP2, A_SP3,
    F_RD, F_EV, F_UNLINK, F_HD, F_HDEV, F_PUSH, F_QRD, F_QEV, F_INS, F_INS2,
    R_START, R_CHK, R_PSTART, R_PRD, R_PEV, R_MW1, R_MW2, R_MW3, R_OUTER, R_TLD,
    S_ARD, S_ALD, S_BRD, S_BEV, S_AWR
  } state_t;

  state_t            state_r, state_nxt;
  logic [LW-1:0]     free_head_r, free_head_nxt;
  logic [LW-1:0]     spare_head_r, spare_head_nxt;
  logic [LW-1:0]     used_head_r, used_head_nxt;
  logic [ADDR_W-1:0] pool_base_r, pool_base_nxt;
  logic [ADDR_W-1:0] pool_bytes_r, pool_bytes_nxt;
  logic [AW-1:0]     init_idx_r, init_idx_nxt;
  logic [31:0]       req_r, req_nxt;
  logic [12:0]       al_r, al_nxt;
  logic [31:0]       addr_r, addr_nxt;
  logic [12:0]       rem_r, rem_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [32:0]       size_r, size_nxt;
  logic [LW-1:0]     cur_r, cur_nxt;
  logic [LW-1:0]     prev_r, prev_nxt;
  logic [LW-1:0]     t_r, t_nxt;
  logic [LW-1:0]     p_r, p_nxt;
  desc_t             cur_w_r, cur_w_nxt;
  desc_t             prev_w_r, prev_w_nxt;
  desc_t             t_w_r, t_w_nxt;
  logic              merged_r, merged_nxt;
  logic              out_valid_r, out_valid_nxt;
  dlha_out_t         out_r, out_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  desc_t             ram_wdata, rd;
  logic [DW-1:0]     ram_rdata;
  logic [13:0]       div_sh;
  logic [33:0]       len34, size34;
  logic              big_pool;

  dlha_ram #(.WIDTH(DW), .DEPTH(NUM_DESC)) u_desc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd        = desc_t'(ram_rdata);
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign div_sh    = {rem_r, addr_r[31]};
  assign len34     = {2'b00, rd.len};
  assign size34    = {1'b0, size_r};
  assign big_pool  = (pool_bytes_r > TOTAL);

  always_comb begin
    state_nxt      = state_r;
    free_head_nxt  = free_head_r;
    spare_head_nxt = spare_head_r;
    used_head_nxt  = used_head_r;
    pool_base_nxt  = pool_base_r;
    pool_bytes_nxt = pool_bytes_r;
    init_idx_nxt   = init_idx_r;
    req_nxt        = req_r;
    al_nxt         = al_r;
    addr_nxt       = addr_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    size_nxt       = size_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    t_nxt          = t_r;
    p_nxt          = p_r;
    cur_w_nxt      = cur_w_r;
    prev_w_nxt     = prev_w_r;
    t_w_nxt        = t_w_r;
    merged_nxt     = merged_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = '0;

    case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = init_idx_r;
        if (init_idx_r == '0 && big_pool) begin
          ram_wdata = '{base: pool_base_r + TOTAL, len: pool_bytes_r - TOTAL, link: NIL};
        end else begin
          ram_wdata.link = (init_idx_r == AW'(NUM_DESC - 1)) ? NIL
                           : LW'(init_idx_r) + LW'(1);
        end
        init_idx_nxt = init_idx_r + AW'(1);
        if (init_idx_r == AW'(NUM_DESC - 1)) begin
          init_idx_nxt   = '0;
          used_head_nxt  = NIL;
          free_head_nxt  = big_pool ? LW'(0) : NIL;
          spare_head_nxt = big_pool ? LW'(1) : LW'(0);
          state_nxt      = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_nxt  = (in_data.req_size == '0) ? 32'd1 : in_data.req_size;
          al_nxt   = (in_data.alignment == '0) ? 13'd1 : in_data.alignment;
          rem_nxt  = '0;
          cnt_nxt  = '0;
          prev_nxt = NIL;
          case (in_data.cmd)
            CMD_ALLOC: begin
              addr_nxt  = (in_data.req_size == '0) ? 32'd1 : in_data.req_size;
              state_nxt = A_DIV;
            end
            CMD_RELEASE: begin
              addr_nxt  = in_data.block_address;
              cur_nxt   = used_head_r;
              state_nxt = F_RD;
            end
            CMD_RECYCLE: state_nxt = R_START;
            default: begin
              out_valid_nxt = 1'b1;
              out_nxt       = '{granted_address: '0, status: ST_OK};
            end
          endcase
        end
      end

      A_DIV: begin
        addr_nxt = {addr_r[30:0], 1'b0};
        rem_nxt  = (div_sh >= 14'(al_r)) ? 13'(div_sh - 14'(al_r)) : div_sh[12:0];
        cnt_nxt  = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          state_nxt = A_SIZE;
        end
      end
      A_SIZE: begin
        size_nxt  = (rem_r == '0) ? {1'b0, req_r}
                    : {1'b0, req_r} - 33'(rem_r) + 33'(al_r);
        cur_nxt   = free_head_r;
        state_nxt = A_RD;
      end
      A_RD: begin
        ram_raddr = cur_r[AW-1:0];
        state_nxt = (cur_r == NIL) ? A_SPLIT : A_EV;
      end
      A_EV: begin
        if (len34 < size34 || len34 > {size34[32:0], 1'b0}) begin
          prev_nxt   = cur_r;
          prev_w_nxt = rd;
          cur_nxt    = rd.link;
          state_nxt  = A_RD;
        end else begin
          cur_w_nxt = rd;
          state_nxt = A_UNLINK;
        end
      end
      A_UNLINK: begin
        if (prev_r == NIL) begin
          free_head_nxt = cur_w_r.link;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = prev_r[AW-1:0];
          ram_wdata = '{base: prev_w_r.base, len: prev_w_r.len, link: cur_w_r.link};
        end
        state_nxt = A_TAKE;
      end
      A_TAKE: begin
        ram_we        = 1'b1;
        ram_waddr     = cur_r[AW-1:0];
        ram_wdata     = '{base: cur_w_r.base, len: cur_w_r.len, link: used_head_r};
        used_head_nxt = cur_r;
        out_valid_nxt = 1'b1;
        out_nxt       = '{granted_address: cur_w_r.base, status: ST_OK};
        state_nxt     = S_IDLE;
      end
      A_SPLIT: begin
        ram_raddr = spare_head_r[AW-1:0];
        if (spare_head_r == NIL) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{granted_address: '0, status: ST_NO_SPARE};
          state_nxt     = S_IDLE;
        end else if (prev_r == NIL || size_r > {1'b0, prev_w_r.len}) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{granted_address: '0, status: ST_NO_MEM};
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = A_SP2;
        end
      end
      A_SP2: begin
        ram_we         = 1'b1;
        ram_waddr      = spare_head_r[AW-1:0];
        ram_wdata      = '{base: prev_w_r.base, len: size_r[31:0], link: used_head_r};
        used_head_nxt  = spare_head_r;
        spare_head_nxt = rd.link;
        state_nxt      = A_SP3;
      end
      A_SP3: begin
        ram_we        = 1'b1;
        ram_waddr     = prev_r[AW-1:0];
        ram_wdata     = '{base: prev_w_r.base + size_r[31:0],
                          len: prev_w_r.len - size_r[31:0], link: prev_w_r.link};
        out_valid_nxt = 1'b1;
        out_nxt       = '{granted_address: prev_w_r.base, status: ST_OK};
        state_nxt     = S_IDLE;
      end

      F_RD: begin
        ram_raddr = cur_r[AW-1:0];
        if (cur_r == NIL) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{granted_address: '0, status: ST_NOT_ALLOC};
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = F_EV;
        end
      end
      F_EV: begin
        if (rd.base == addr_r) begin
          cur_w_nxt = rd;
          state_nxt = F_UNLINK;
        end else begin
          prev_nxt   = cur_r;
          prev_w_nxt = rd;
          cur_nxt    = rd.link;
          state_nxt  = F_RD;
        end
      end
      F_UNLINK: begin
        if (prev_r == NIL) begin
          used_head_nxt = cur_w_r.link;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = prev_r[AW-1:0];
          ram_wdata = '{base: prev_w_r.base, len: prev_w_r.len, link: cur_w_r.link};
        end
        state_nxt = F_HD;
      end
      F_HD: begin
        ram_raddr = free_head_r[AW-1:0];
        state_nxt = (free_head_r == NIL) ? F_PUSH : F_HDEV;
      end
      F_HDEV: begin
        if (rd.len >= cur_w_r.len) begin
          state_nxt = F_PUSH;
        end else begin
          p_nxt      = free_head_r;
          prev_w_nxt = rd;
          t_nxt      = rd.link;
          state_nxt  = F_QRD;
        end
      end
      F_PUSH: begin
        ram_we        = 1'b1;
        ram_waddr     = cur_r[AW-1:0];
        ram_wdata     = '{base: cur_w_r.base, len: cur_w_r.len, link: free_head_r};
        free_head_nxt = cur_r;
        out_valid_nxt = 1'b1;
        out_nxt       = '{granted_address: '0, status: ST_OK};
        state_nxt     = S_IDLE;
      end
      F_QRD: begin
        ram_raddr = t_r[AW-1:0];
        state_nxt = (t_r == NIL) ? F_INS : F_QEV;
      end
      F_QEV: begin
        if (rd.len < cur_w_r.len) begin
          p_nxt      = t_r;
          prev_w_nxt = rd;
          t_nxt      = rd.link;
          state_nxt  = F_QRD;
        end else begin
          state_nxt = F_INS;
        end
      end
      F_INS: begin
        ram_we    = 1'b1;
        ram_waddr = p_r[AW-1:0];
        ram_wdata = '{base: prev_w_r.base, len: prev_w_r.len, link: cur_r};
        state_nxt = F_INS2;
      end
      F_INS2: begin
        ram_we        = 1'b1;
        ram_waddr     = cur_r[AW-1:0];
        ram_wdata     = '{base: cur_w_r.base, len: cur_w_r.len, link: t_r};
        out_valid_nxt = 1'b1;
        out_nxt       = '{granted_address: '0, status: ST_OK};
        state_nxt     = S_IDLE;
      end

      R_START: begin
        ram_raddr = free_head_r[AW-1:0];
        if (free_head_r == NIL) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{granted_address: '0, status: ST_OK};
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = R_CHK;
        end
      end
      R_CHK: begin
        if (rd.link == NIL) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{granted_address: '0, status: ST_OK};
          state_nxt     = S_IDLE;
        end else begin
          t_nxt     = free_head_r;
          t_w_nxt   = rd;
          state_nxt = R_PSTART;
        end
      end
      R_PSTART: begin
        merged_nxt = 1'b0;
        p_nxt      = free_head_r;
        prev_nxt   = NIL;
        state_nxt  = R_PRD;
      end
      R_PRD: begin
        ram_raddr = p_r[AW-1:0];
        state_nxt = (p_r == NIL) ? R_OUTER : R_PEV;
      end
      R_PEV: begin
        if (p_r != t_r && (t_w_r.base + t_w_r.len) == rd.base) begin
          merged_nxt  = 1'b1;
          t_w_nxt.len = t_w_r.len + rd.len;
          cur_nxt     = rd.link;
          if (prev_r == NIL) begin
            free_head_nxt = rd.link;
          end else if (prev_r == t_r) begin
            t_w_nxt.link = rd.link;
          end
          state_nxt = R_MW1;
        end else begin
          prev_nxt   = p_r;
          prev_w_nxt = rd;
          p_nxt      = rd.link;
          state_nxt  = R_PRD;
        end
      end
      R_MW1: begin
        ram_we    = 1'b1;
        ram_waddr = t_r[AW-1:0];
        ram_wdata = t_w_r;
        state_nxt = R_MW2;
      end
      R_MW2: begin
        if (prev_r != NIL && prev_r != t_r) begin
          ram_we          = 1'b1;
          ram_waddr       = prev_r[AW-1:0];
          ram_wdata       = '{base: prev_w_r.base, len: prev_w_r.len, link: cur_r};
          prev_w_nxt.link = cur_r;
        end
        state_nxt = R_MW3;
      end
      R_MW3: begin
        ram_we         = 1'b1;
        ram_waddr      = p_r[AW-1:0];
        ram_wdata      = '{base: '0, len: '0, link: spare_head_r};
        spare_head_nxt = p_r;
        p_nxt          = cur_r;
        state_nxt      = R_PRD;
      end
      R_OUTER: begin
        ram_raddr = t_w_r.link[AW-1:0];
        if (merged_r) begin
          state_nxt = R_PSTART;
        end else if (t_w_r.link == NIL) begin
          t_nxt     = free_head_r;
          state_nxt = S_ARD;
        end else begin
          t_nxt     = t_w_r.link;
          state_nxt = R_TLD;
        end
      end
      R_TLD: begin
        t_w_nxt   = rd;
        state_nxt = R_PSTART;
      end

      S_ARD: begin
        ram_raddr = t_r[AW-1:0];
        if (t_r == NIL) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{granted_address: '0, status: ST_OK};
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_ALD;
        end
      end
      S_ALD: begin
        t_w_nxt   = rd;
        p_nxt     = rd.link;
        state_nxt = S_BRD;
      end
      S_BRD: begin
        ram_raddr = p_r[AW-1:0];
        state_nxt = (p_r == NIL) ? S_AWR : S_BEV;
      end
      S_BEV: begin
        if (t_w_r.len >= rd.len) begin
          ram_we       = 1'b1;
          ram_waddr    = p_r[AW-1:0];
          ram_wdata    = '{base: t_w_r.base, len: t_w_r.len, link: rd.link};
          t_w_nxt.base = rd.base;
          t_w_nxt.len  = rd.len;
        end
        p_nxt     = rd.link;
        state_nxt = S_BRD;
      end
      S_AWR: begin
        ram_we    = 1'b1;
        ram_waddr = t_r[AW-1:0];
        ram_wdata = t_w_r;
        t_nxt     = t_w_r.link;
        state_nxt = S_ARD;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_we) begin
      if (cfg_index == REG_POOL_BASE) begin
        pool_base_nxt = cfg_wdata;
      end else begin
        pool_bytes_nxt = cfg_wdata;
      end
      init_idx_nxt = '0;
      state_nxt    = S_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      init_idx_r   <= '0;
      pool_base_r  <= '0;
      pool_bytes_r <= ADDR_W'(65536);
      free_head_r  <= NIL;
      spare_head_r <= NIL;
      used_head_r  <= NIL;
      merged_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      init_idx_r   <= init_idx_nxt;
      pool_base_r  <= pool_base_nxt;
      pool_bytes_r <= pool_bytes_nxt;
      free_head_r  <= free_head_nxt;
      spare_head_r <= spare_head_nxt;
      used_head_r  <= used_head_nxt;
      merged_r     <= merged_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    req_r    <= req_nxt;
    al_r     <= al_nxt;
    addr_r   <= addr_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
    size_r   <= size_nxt;
    cur_r    <= cur_nxt;
    prev_r   <= prev_nxt;
    t_r      <= t_nxt;
    p_r      <= p_nxt;
    cur_w_r  <= cur_w_nxt;
    prev_w_r <= prev_w_nxt;
    t_w_r    <= t_w_nxt;
    out_r    <= out_nxt;
  end

  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || start))
    else $error("result without a command in flight");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |-> (out_data.granted_address == '0))
    else $error("failed transaction carries an address");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !cfg_we) |=> busy || out_valid)
    else $error("accepted transaction dropped");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid || $past(start && !busy))
    else $error("result strobe repeated");

endmodule
`default_nettype wire

>>> dv/descriptor_list_heap_allocator_tb.sv
`timescale 1ns / 100ps

module descriptor_list_heap_allocator_tb;
  import dlha_pkg::*;

  localparam int NUM_DESC   = 64;
  localparam int DESC_BYTES = 24;
  localparam int NIL        = NUM_DESC;
  localparam longint LIMIT  = 50000000;

  class heap_scoreboard;
    logic [31:0] dbase [NUM_DESC];
    logic [31:0] dlen  [NUM_DESC];
    int          dlink [NUM_DESC];
    int          free_hd, spare_hd, used_hd;
    logic [31:0] pbase, pbytes;
    dlha_out_t   pending_grants[$];
    logic [31:0] live_blocks[$];
    int          errors;

    function new();
      pbase   = 32'd0;
      pbytes  = 32'd65536;
      errors  = 0;
      rebuild();
    endfunction

    function void rebuild();
      bit [63:0] total;
      total = 64'(NUM_DESC * DESC_BYTES);
      for (int i = 0; i < NUM_DESC; i++) begin
        dbase[i] = '0;
        dlen[i]  = '0;
        dlink[i] = i + 1;
      end
      used_hd = NIL;
      live_blocks.delete();
      if ({32'd0, pbytes} > total) begin
        dbase[0] = pbase + total[31:0];
        dlen[0]  = pbytes - total[31:0];
        dlink[0] = NIL;
        free_hd  = 0;
        spare_hd = 1;
      end else begin
        free_hd  = NIL;
        spare_hd = 0;
      end
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] val);
      if (idx == REG_POOL_BASE) pbase = val;
      else pbytes = val;
      rebuild();
    endfunction

    function status_t grant(logic [31:0] req, logic [12:0] al, output logic [31:0] addr);
      bit [63:0] size, rq, ag;
      int prev, cur, n, nx, nd;
      prev = NIL;
      cur  = free_hd;
      n    = 0;
      addr = '0;
      rq = (req == 0) ? 64'd1 : {32'd0, req};
      ag = (al == 0) ? 64'd1 : {51'd0, al};
      size = (rq % ag != 0) ? (rq / ag + 1) * ag : rq;
      while (cur < NUM_DESC && n < NUM_DESC) begin
        nx = dlink[cur];
        if ({32'd0, dlen[cur]} < size || {32'd0, dlen[cur]} > 2 * size) begin
          prev = cur;
          cur  = nx;
        end else begin
          if (cur == free_hd) free_hd = nx;
          else if (prev < NUM_DESC) dlink[prev] = nx;
          dlink[cur] = used_hd;
          used_hd    = cur;
          addr       = dbase[cur];
          return ST_OK;
        end
        n++;
      end
      if (spare_hd >= NUM_DESC) return ST_NO_SPARE;
      if (prev >= NUM_DESC) return ST_NO_MEM;
      if (size > {32'd0, dlen[prev]}) return ST_NO_MEM;
      nd          = spare_hd;
      spare_hd    = dlink[nd];
      dbase[nd]   = dbase[prev];
      dlen[nd]    = size[31:0];
      dlink[nd]   = used_hd;
      used_hd     = nd;
      dlen[prev]  = dlen[prev] - size[31:0];
      dbase[prev] = dbase[prev] + size[31:0];
      addr        = dbase[nd];
      return ST_OK;
    endfunction

    function status_t give_back(logic [31:0] a);
      int prev, cur, n, p, q;
      prev = NIL;
      cur  = used_hd;
      n    = 0;
      while (cur < NUM_DESC && n < NUM_DESC && dbase[cur] != a) begin
        prev = cur;
        cur  = dlink[cur];
        n++;
      end
      if (cur >= NUM_DESC) return ST_NOT_ALLOC;
      if (dbase[cur] != a) return ST_NOT_ALLOC;
      if (cur == used_hd) used_hd = dlink[cur];
      else if (prev < NUM_DESC) dlink[prev] = dlink[cur];
      if (free_hd >= NUM_DESC || dlen[free_hd] >= dlen[cur]) begin
        dlink[cur] = free_hd;
        free_hd    = cur;
      end else begin
        p = free_hd;
        q = dlink[free_hd];
        n = 0;
        while (q < NUM_DESC && n < NUM_DESC && dlen[q] < dlen[cur]) begin
          p = q;
          q = dlink[q];
          n++;
        end
        dlink[p]   = cur;
        dlink[cur] = q;
      end
      return ST_OK;
    endfunction

    function void sort_by_length();
      int a, b, na, nb;
      logic [31:0] tb, tl;
      a  = free_hd;
      na = 0;
      while (a < NUM_DESC && na < NUM_DESC) begin
        b  = dlink[a];
        nb = 0;
        while (b < NUM_DESC && nb < NUM_DESC) begin
          if (dlen[a] >= dlen[b]) begin
            tb = dbase[a];
            tl = dlen[a];
            dbase[a] = dbase[b];
            dlen[a]  = dlen[b];
            dbase[b] = tb;
            dlen[b]  = tl;
          end
          b = dlink[b];
          nb++;
        end
        a = dlink[a];
        na++;
      end
    endfunction

    function void merge_free();
      int t, guard, prev, p, n, nx;
      bit merged;
      logic [31:0] tail;
      if (free_hd >= NUM_DESC) return;
      if (dlink[free_hd] >= NUM_DESC) return;
      t = free_hd;
      guard = 0;
      while (t < NUM_DESC && guard < 2 * NUM_DESC + 2) begin
        merged = 0;
        prev = NIL;
        p = free_hd;
        n = 0;
        while (p < NUM_DESC && n < NUM_DESC) begin
          nx = dlink[p];
          tail = dbase[t] + dlen[t];
          if (p != t && tail == dbase[p]) begin
            merged  = 1;
            dlen[t] = dlen[t] + dlen[p];
            if (p == free_hd) free_hd = nx;
            else if (prev < NUM_DESC) dlink[prev] = nx;
            dbase[p] = '0;
            dlen[p]  = '0;
            dlink[p] = spare_hd;
            spare_hd = p;
          end else begin
            prev = p;
          end
          p = nx;
          n++;
        end
        if (!merged) t = dlink[t];
        guard++;
      end
      sort_by_length();
    endfunction

    function void note_transaction(dlha_in_t it);
      dlha_out_t exp_res;
      logic [31:0] addr;
      exp_res = '0;
      exp_res.status = ST_OK;
      case (it.cmd)
        CMD_ALLOC: begin
          exp_res.status = grant(it.req_size, it.alignment, addr);
          if (exp_res.status == ST_OK) begin
            exp_res.granted_address = addr;
            live_blocks.push_back(addr);
          end
        end
        CMD_RELEASE: begin
          exp_res.status = give_back(it.block_address);
          if (exp_res.status == ST_OK) begin
            foreach (live_blocks[i]) begin
              if (live_blocks[i] == it.block_address) begin
                live_blocks.delete(i);
                break;
              end
            end
          end
        end
        CMD_RECYCLE: merge_free();
        default: ;
      endcase
      pending_grants.push_back(exp_res);
    endfunction

    function void check_result(dlha_out_t got);
      dlha_out_t exp_res;
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual addr %h status %s",
                 $realtime, got.granted_address, got.status.name());
        errors++;
        return;
      end
      exp_res = pending_grants.pop_front();
      if (got.granted_address !== exp_res.granted_address) begin
        $display("%0t: granted_address mismatch, expected %h, actual %h",
                 $realtime, exp_res.granted_address, got.granted_address);
        errors++;
      end
      if (got.status !== exp_res.status) begin
        $display("%0t: status mismatch, expected %s, actual %s",
                 $realtime, exp_res.status.name(), got.status.name());
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  dlha_in_t    in_data;
  logic        out_valid;
  dlha_out_t   out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;

  heap_scoreboard sb;
  longint        cycles = 0;
  bit            no_gaps;

  descriptor_list_heap_allocator #(
    .NUM_DESC   (NUM_DESC),
    .DESC_BYTES (DESC_BYTES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  task automatic send(dlha_in_t it);
    int gap;
    in_data <= it;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_transaction(it);
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending_grants.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic dlha_in_t make_op(cmd_t c, logic [31:0] sz, logic [12:0] al,
                                       logic [31:0] a);
    dlha_in_t it;
    it.cmd           = c;
    it.req_size      = sz;
    it.alignment     = al;
    it.block_address = a;
    return it;
  endfunction

  function automatic logic [12:0] pick_alignment();
    case ($urandom_range(0, 3))
      0: return 13'd1;
      1: return 13'd1 << $urandom_range(0, 12);
      2: return 13'($urandom_range(0, 8191));
      default: return 13'($urandom_range(1, 64));
    endcase
  endfunction

  task automatic run_random(int count, int max_size);
    dlha_in_t it;
    int r;
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      it = make_op(CMD_ALLOC, $urandom, pick_alignment(), $urandom);
      if (r < 50) begin
        if ($urandom_range(0, 9) != 0) it.req_size = $urandom_range(0, max_size);
      end else if (r < 88) begin
        it.cmd = CMD_RELEASE;
        if (sb.live_blocks.size() != 0 && $urandom_range(0, 6) != 0)
          it.block_address = sb.live_blocks[$urandom_range(0, sb.live_blocks.size() - 1)];
      end else if (r < 96) begin
        it.cmd = CMD_RECYCLE;
      end else begin
        it.cmd = CMD_NONE;
      end
      send(it);
    end
    no_gaps = 0;
  endtask

  initial begin
    sb        = new();
    no_gaps   = 0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_POOL_BASE;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);

    send(make_op(CMD_RECYCLE, 32'd0, 13'd0, 32'd0));
    send(make_op(CMD_ALLOC, 32'd0, 13'd0, 32'd0));
    send(make_op(CMD_ALLOC, 32'd100, 13'd4096, 32'd0));
    send(make_op(CMD_ALLOC, 32'd5, 13'd8191, 32'hFFFFFFFF));
    send(make_op(CMD_ALLOC, 32'hFFFFFFFF, 13'd4096, 32'd0));
    send(make_op(CMD_ALLOC, 32'd64, 13'd1, 32'd0));
    send(make_op(CMD_ALLOC, 32'd64, 13'd3, 32'd0));
    send(make_op(CMD_RELEASE, 32'd0, 13'd0, 32'hFFFFFFFF));
    send(make_op(CMD_RELEASE, 32'd0, 13'd0, 32'd0));
    send(make_op(CMD_RELEASE, 32'd0, 13'd0, sb.live_blocks[1]));
    send(make_op(CMD_RELEASE, 32'd0, 13'd0, sb.live_blocks[1]));
    send(make_op(CMD_ALLOC, 32'd64, 13'd1, 32'd0));
    send(make_op(CMD_RELEASE, 32'd0, 13'd0, sb.live_blocks[0]));
    send(make_op(CMD_RELEASE, 32'd0, 13'd0, sb.live_blocks[0]));
    send(make_op(CMD_RECYCLE, 32'd0, 13'd0, 32'd0));
    send(make_op(CMD_NONE, 32'hFFFFFFFF, 13'h1FFF, 32'hFFFFFFFF));
    send(make_op(CMD_ALLOC, 32'd64000, 13'd1, 32'd0));
    send(make_op(CMD_ALLOC, 32'd1, 13'd1, 32'd0));
    run_random(140, 600);

    write_reg(REG_POOL_BASE, 32'hFFFFF000);
    write_reg(REG_POOL_BYTES, 32'h00004000);
    run_random(90, 900);

    write_reg(REG_POOL_BYTES, 32'd0);
    run_random(15, 100);

    write_reg(REG_POOL_BASE, 32'd0);
    write_reg(REG_POOL_BYTES, 32'hFFFFFFFF);
    run_random(80, 32'h7FFFFFFF);

    write_reg(REG_POOL_BASE, 32'h12345678);
    write_reg(REG_POOL_BYTES, NUM_DESC * DESC_BYTES + 1);
    run_random(15, 4);

    write_reg(REG_POOL_BYTES, 32'd3000);
    run_random(70, 200);

    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending_grants.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
